FILE: rtl/ohlc_pkg.sv
package ohlc_pkg;

  // Bar memory geometry
  localparam int NUM_BARS = 1024;
  localparam int ADDR_W   = $clog2(NUM_BARS);

  // Divider step counts: integer bar index and Q32.32 fraction
  localparam int INT_STEPS = 32;
  localparam int Q_STEPS   = 64;
  localparam int CNT_W     = $clog2(Q_STEPS + 1);

  localparam logic [31:0] MIN_BAR_SECONDS = 32'd60;

  // Input action codes
  localparam logic [1:0] ACT_TRADE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_SMALL   = 3'd1;
  localparam logic [2:0] ST_OUTWIN  = 3'd2;
  localparam logic [2:0] ST_READ    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;
  localparam logic [2:0] ST_BAD     = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_WSTART = 2'd0;
  localparam logic [1:0] CFG_WEND   = 2'd1;
  localparam logic [1:0] CFG_BARSEC = 2'd2;
  localparam logic [1:0] CFG_MINVOL = 2'd3;

  // One bar entry as stored in memory
  typedef struct packed {
    logic [31:0] first_seen;
    logic [31:0] last_seen;
    logic [63:0] open_price;
    logic [63:0] close_price;
    logic [63:0] high_price;
    logic [63:0] low_price;
    logic [63:0] base_sum;
    logic [63:0] rel_sum;
    logic [31:0] count_in_bar;
  } bar_t;

  // Divider control and status
  typedef struct packed {
    logic start;
    logic q_mode;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Result item
  typedef struct packed {
    logic [2:0]  status;
    logic        bar_valid;
    logic [31:0] bar_start;
    logic [63:0] price_high;
    logic [63:0] price_low;
    logic [63:0] price_open;
    logic [63:0] price_close;
    logic [63:0] rel_total;
    logic [63:0] base_total;
    logic [63:0] average_price;
    logic [31:0] trade_count;
  } res_t;

endpackage

FILE: rtl/ohlc_div.sv
module ohlc_div import ohlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  div_ctl_t    ctl,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output div_stat_t   stat,
  output logic [63:0] quo
);

  logic [63:0]      rem_r;
  logic [63:0]      sh_r;
  logic [63:0]      quo_r;
  logic [63:0]      den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [64:0] trial;
  logic        fits;

  // One restoring step: shift in next dividend bit, subtract if it fits
  assign trial = {rem_r, sh_r[63]};
  assign fits  = trial >= {1'b0, den_r};

  // Control: start, count steps, pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        if (ctl.q_mode && (num[63:32] >= den)) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= ctl.q_mode ? CNT_W'(Q_STEPS) : CNT_W'(INT_STEPS);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      den_r <= den;
      sh_r  <= {num[31:0], 32'd0};
      if (ctl.q_mode) begin
        rem_r <= {32'd0, num[63:32]};
        quo_r <= (num[63:32] >= den) ? '1 : '0;
      end else begin
        rem_r <= '0;
        quo_r <= '0;
      end
    end else if (busy_r) begin
      sh_r  <= {sh_r[62:0], 1'b0};
      quo_r <= {quo_r[62:0], fits};
      rem_r <= fits ? 64'(trial - {1'b0, den_r}) : trial[63:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r) else $error("divider started while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("divider busy with zero count");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");

endmodule

FILE: rtl/ohlc_ram.sv
module ohlc_ram import ohlc_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  bar_t              wdata,
  output bar_t              rdata
);

  bar_t mem [NUM_BARS];
  bar_t rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/trade_ohlc_bar_aggregator_unit.sv
// OHLC bar aggregator. Per-bar state lives in one synchronous memory of
// NUM_BARS entries. After reset, a clearing pass writes one entry a cycle
// over all NUM_BARS entries (1024), with in_ready low. Items are handled one
// at a time, and one serial divider does all the division. Steps per item:
// - a trade: a 32-step division for the bar index, a 64-step division for
//   the Q32.32 price, then a read-modify-write of the bar entry. The price
//   division does no steps when the price saturates.
// - a trade whose timestamp lands past the last bar, or whose volume is too
//   small, ends after the bar-index division.
// - a read: a memory read plus the 64-step average-price division, which
//   does no steps when base_total is zero or the average saturates.
// - a clear, an out-of-window trade or a bad request goes straight to the
//   result.
// in_ready comes back on the cycle after the result is loaded, and the next
// item can be accepted from then on. One finished result may wait in the
// output register while the next item is accepted. A second result that is
// done while the first still waits holds the block.
module trade_ohlc_bar_aggregator_unit import ohlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_trade_time,
  input  logic [47:0] in_base_volume,
  input  logic [47:0] in_rel_volume,
  input  logic [9:0]  in_bar_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_bar_valid,
  output logic [31:0] out_bar_start,
  output logic [63:0] out_price_high,
  output logic [63:0] out_price_low,
  output logic [63:0] out_price_open,
  output logic [63:0] out_price_close,
  output logic [63:0] out_rel_total,
  output logic [63:0] out_base_total,
  output logic [63:0] out_average_price,
  output logic [31:0] out_trade_count
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DISP  = 11'b00000000100,
    S_IDX   = 11'b00000001000,
    S_PDIV  = 11'b00000010000,
    S_TRD   = 11'b00000100000,
    S_TUPD  = 11'b00001000000,
    S_RRD   = 11'b00010000000,
    S_RDAT  = 11'b00100000000,
    S_AVG   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [31:0]       ws_r, wend_r, bs_r;
  logic [47:0]       minv_r;

  logic [1:0]        act_r;
  logic [31:0]       time_r;
  logic [47:0]       basev_r, relv_r;
  logic [9:0]        sel_r;
  logic [ADDR_W-1:0] idx_r;
  logic [63:0]       price_r;
  logic [31:0]       prod_r;
  bar_t              bar_r;
  res_t              res_r;
  res_t              out_r;
  logic              out_valid_r;

  logic [31:0]       eff_bs;
  logic              sel_bad;
  logic              out_win;
  logic              small_vol;
  logic              idx_over;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  bar_t              mem_wdata, mem_rdata, upd;

  div_ctl_t          div_ctl;
  div_stat_t         div_stat;
  logic [63:0]       div_num, div_den, div_quo;

  ohlc_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ohlc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= '0;
      wend_r <= '1;
      bs_r   <= MIN_BAR_SECONDS;
      minv_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WSTART: ws_r   <= cfg_wdata[31:0];
        CFG_WEND:   wend_r <= cfg_wdata[31:0];
        CFG_BARSEC: bs_r   <= cfg_wdata[31:0];
        CFG_MINVOL: minv_r <= cfg_wdata;
        default:    ws_r   <= ws_r;
      endcase
    end
  end

  // Decode checks on the held item
  assign eff_bs    = (bs_r < MIN_BAR_SECONDS) ? MIN_BAR_SECONDS : bs_r;
  assign sel_bad   = 32'(sel_r) >= 32'(NUM_BARS);
  assign out_win   = (time_r == '0) || (time_r < ws_r) || (time_r > wend_r);
  assign small_vol = (basev_r <= minv_r) || (relv_r <= minv_r);
  assign idx_over  = div_quo[31:0] >= 32'(NUM_BARS);

  // Merge one trade into the bar entry
  always_comb begin
    upd = mem_rdata;
    if ((mem_rdata.first_seen == '0) || (time_r < mem_rdata.first_seen)) begin
      upd.first_seen = time_r;
      upd.open_price = price_r;
    end
    if ((mem_rdata.last_seen == '0) || (time_r > mem_rdata.last_seen)) begin
      upd.last_seen   = time_r;
      upd.close_price = price_r;
    end
    if ((mem_rdata.low_price == '0) || (price_r < mem_rdata.low_price)) begin
      upd.low_price = price_r;
    end
    if ((mem_rdata.high_price == '0) || (price_r > mem_rdata.high_price)) begin
      upd.high_price = price_r;
    end
    upd.base_sum = ({1'b0, mem_rdata.base_sum} + 65'(basev_r) > 65'h0_FFFF_FFFF_FFFF_FFFF)
                   ? '1 : 64'(mem_rdata.base_sum + 64'(basev_r));
    upd.rel_sum  = ({1'b0, mem_rdata.rel_sum} + 65'(relv_r) > 65'h0_FFFF_FFFF_FFFF_FFFF)
                   ? '1 : 64'(mem_rdata.rel_sum + 64'(relv_r));
    if (mem_rdata.count_in_bar != '1) begin
      upd.count_in_bar = mem_rdata.count_in_bar + 32'd1;
    end
  end

  // Memory and divider control per state
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = idx_r;
    mem_wdata   = '0;
    div_ctl     = '0;
    div_num     = {16'd0, relv_r};
    div_den     = {16'd0, basev_r};
    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
      end
      S_DISP: begin
        mem_addr = ADDR_W'(sel_r);
        if ((act_r == ACT_CLEAR) && !sel_bad) begin
          mem_we = 1'b1;
        end
        if ((act_r == ACT_TRADE) && !out_win) begin
          div_ctl.start = 1'b1;
          div_num       = {32'd0, 32'(time_r - ws_r)};
          div_den       = {32'd0, eff_bs};
        end
      end
      S_IDX: begin
        if (div_stat.done && !idx_over && !small_vol) begin
          div_ctl.start  = 1'b1;
          div_ctl.q_mode = 1'b1;
        end
      end
      S_TRD:  mem_re = 1'b1;
      S_TUPD: begin
        mem_we    = 1'b1;
        mem_wdata = upd;
      end
      S_RRD: begin
        mem_re   = 1'b1;
        mem_addr = ADDR_W'(sel_r);
      end
      S_RDAT: begin
        div_ctl.start  = 1'b1;
        div_ctl.q_mode = 1'b1;
        div_num        = mem_rdata.rel_sum;
        div_den        = mem_rdata.base_sum;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == ADDR_W'(NUM_BARS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        if ((act_r == ACT_TRADE) && !out_win) begin
          state_nxt = S_IDX;
        end else if ((act_r == ACT_READ) && !sel_bad) begin
          state_nxt = S_RRD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_IDX: begin
        if (div_stat.done) begin
          state_nxt = (idx_over || small_vol) ? S_OUT : S_PDIV;
        end
      end
      S_PDIV:  if (div_stat.done) state_nxt = S_TRD;
      S_TRD:   state_nxt = S_TUPD;
      S_TUPD:  state_nxt = S_OUT;
      S_RRD:   state_nxt = S_RDAT;
      S_RDAT:  state_nxt = S_AVG;
      S_AVG:   if (div_stat.done) state_nxt = S_OUT;
      S_OUT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if ((state_r == S_OUT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the transaction and build the result
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        act_r   <= in_action;
        time_r  <= in_trade_time;
        basev_r <= in_base_volume;
        relv_r  <= in_rel_volume;
        sel_r   <= in_bar_select;
      end
      S_DISP: begin
        res_r <= '0;
        if (act_r == ACT_TRADE) begin
          res_r.status <= ST_OUTWIN;
        end else if ((act_r == ACT_CLEAR) && !sel_bad) begin
          res_r.status <= ST_CLEARED;
        end else begin
          res_r.status <= ST_BAD;
        end
      end
      S_IDX: begin
        idx_r <= ADDR_W'(div_quo);
        if (div_stat.done && !idx_over) begin
          res_r.status <= ST_SMALL;
        end
      end
      S_PDIV: price_r <= div_quo;
      S_TUPD: res_r.status <= ST_ADDED;
      S_RRD:  prod_r <= 32'(sel_r * eff_bs);
      S_RDAT: bar_r <= mem_rdata;
      S_AVG: begin
        res_r.status        <= ST_READ;
        res_r.bar_valid     <= (bar_r.count_in_bar != '0) &&
                               (bar_r.rel_sum > 64'(minv_r)) &&
                               (bar_r.base_sum > 64'(minv_r));
        res_r.bar_start     <= ws_r + prod_r;
        res_r.price_high    <= bar_r.high_price;
        res_r.price_low     <= bar_r.low_price;
        res_r.price_open    <= bar_r.open_price;
        res_r.price_close   <= bar_r.close_price;
        res_r.rel_total     <= bar_r.rel_sum;
        res_r.base_total    <= bar_r.base_sum;
        res_r.average_price <= (bar_r.base_sum != '0) ? div_quo : '0;
        res_r.trade_count   <= bar_r.count_in_bar;
      end
      S_OUT: if (!out_valid_r || out_ready) out_r <= res_r;
      default: prod_r <= prod_r;
    endcase
  end

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_bar_valid     = out_r.bar_valid;
  assign out_bar_start     = out_r.bar_start;
  assign out_price_high    = out_r.price_high;
  assign out_price_low     = out_r.price_low;
  assign out_price_open    = out_r.price_open;
  assign out_price_close   = out_r.price_close;
  assign out_rel_total     = out_r.rel_total;
  assign out_base_total    = out_r.base_total;
  assign out_average_price = out_r.average_price;
  assign out_trade_count   = out_r.trade_count;

  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !mem_re) else $error("memory read and write in one cycle");
  a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TUPD) |-> $past(state_r == S_TRD))
    else $error("bar update without preceding read");
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r) else $error("result during clearing pass");

endmodule

FILE: verif/ohlc_bar_checker.sv
module ohlc_bar_checker import ohlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_trade_time,
  input  logic [47:0] in_base_volume,
  input  logic [47:0] in_rel_volume,
  input  logic [9:0]  in_bar_select,
  input  logic        out_valid,
  input  logic        out_ready,
  input  res_t        out_res,
  output int          fail_count,
  output int          pending
);

  // Shadow of the block's registers and bar memory
  logic [31:0] win_lo, win_hi, bar_len;
  logic [47:0] vol_floor;
  bar_t        bars [NUM_BARS];
  res_t        expected_q [$];

  function automatic logic [63:0] q32_quotient(logic [63:0] num, logic [63:0] den);
    logic [63:0] ip, r, fr;
    logic        carry;
    ip = num / den;
    r  = num % den;
    fr = '0;
    if (ip > 64'hFFFF_FFFF) return '1;
    for (int i = 0; i < 32; i++) begin
      carry = r[63];
      r  = r << 1;
      fr = fr << 1;
      if (carry || r >= den) begin
        r = r - den;
        fr[0] = 1'b1;
      end
    end
    return {ip[31:0], fr[31:0]};
  endfunction

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] eff_len();
    return (bar_len < MIN_BAR_SECONDS) ? MIN_BAR_SECONDS : bar_len;
  endfunction

  // Apply one transaction to the shadow bars and return the expected result
  function automatic res_t apply_item(logic [1:0] act, logic [31:0] t,
                                      logic [47:0] bv, logic [47:0] rv,
                                      logic [9:0] sel);
    res_t        r;
    logic [31:0] idx;
    logic [63:0] p;
    bar_t        b;
    r = '0;
    if (act == ACT_TRADE) begin
      idx = (t - win_lo) / eff_len();
      if (t == 0 || t < win_lo || t > win_hi || idx >= NUM_BARS) begin
        r.status = ST_OUTWIN;
      end else if (bv <= vol_floor || rv <= vol_floor) begin
        r.status = ST_SMALL;
      end else begin
        p = q32_quotient({16'd0, rv}, {16'd0, bv});
        b = bars[idx];
        if (b.first_seen == 0 || t < b.first_seen) begin
          b.first_seen = t;
          b.open_price = p;
        end
        if (b.last_seen == 0 || t > b.last_seen) begin
          b.last_seen = t;
          b.close_price = p;
        end
        if (b.low_price == 0 || p < b.low_price) b.low_price = p;
        if (b.high_price == 0 || p > b.high_price) b.high_price = p;
        b.base_sum = sum_sat(b.base_sum, {16'd0, bv});
        b.rel_sum  = sum_sat(b.rel_sum, {16'd0, rv});
        if (b.count_in_bar != '1) b.count_in_bar++;
        bars[idx] = b;
        r.status = ST_ADDED;
      end
    end else if (act == ACT_CLEAR) begin
      bars[sel] = '0;
      r.status = ST_CLEARED;
    end else if (act == ACT_READ) begin
      b = bars[sel];
      r.status        = ST_READ;
      r.bar_valid     = b.count_in_bar != 0 && b.rel_sum > vol_floor &&
                        b.base_sum > vol_floor;
      r.bar_start     = win_lo + 32'(sel) * eff_len();
      r.price_high    = b.high_price;
      r.price_low     = b.low_price;
      r.price_open    = b.open_price;
      r.price_close   = b.close_price;
      r.rel_total     = b.rel_sum;
      r.base_total    = b.base_sum;
      r.average_price = b.base_sum != 0 ? q32_quotient(b.rel_sum, b.base_sum) : '0;
      r.trade_count   = b.count_in_bar;
    end else begin
      r.status = ST_BAD;
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  // Track config, predict on accepted inputs, compare on accepted outputs
  always @(posedge clk) begin
    res_t e;
    if (!rst_n) begin
      win_lo <= 32'd0;
      win_hi <= '1;
      bar_len <= 32'd60;
      vol_floor <= '0;
      fail_count <= 0;
      expected_q.delete();
      for (int i = 0; i < NUM_BARS; i++) bars[i] = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WSTART: win_lo <= cfg_wdata[31:0];
          CFG_WEND:   win_hi <= cfg_wdata[31:0];
          CFG_BARSEC: bar_len <= cfg_wdata[31:0];
          CFG_MINVOL: vol_floor <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.push_back(apply_item(in_action, in_trade_time, in_base_volume,
                                        in_rel_volume, in_bar_select));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result status %0d", out_res.status);
        end else begin
          e = expected_q.pop_front();
          if (out_res !== e) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("mismatch: status exp %0d got %0d, valid exp %0b got %0b",
                       e.status, out_res.status, e.bar_valid, out_res.bar_valid);
              $display("  start exp %h got %h, hi exp %h got %h, lo exp %h got %h",
                       e.bar_start, out_res.bar_start, e.price_high,
                       out_res.price_high, e.price_low, out_res.price_low);
              $display("  open exp %h got %h, close exp %h got %h",
                       e.price_open, out_res.price_open, e.price_close,
                       out_res.price_close);
              $display("  rel exp %h got %h, base exp %h got %h",
                       e.rel_total, out_res.rel_total, e.base_total,
                       out_res.base_total);
              $display("  avg exp %h got %h, count exp %0d got %0d",
                       e.average_price, out_res.average_price, e.trade_count,
                       out_res.trade_count);
            end
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb_trade_ohlc_bar_aggregator_unit.sv
module tb_trade_ohlc_bar_aggregator_unit;
  import ohlc_pkg::*;

  localparam int STALL_LIMIT = 20000;

  // Action code that the block answers as a bad request
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_WSTART;
  logic [47:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = ACT_TRADE;
  logic [31:0] in_trade_time = '0;
  logic [47:0] in_base_volume = '0;
  logic [47:0] in_rel_volume = '0;
  logic [9:0]  in_bar_select = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  res_t        out_res;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          calm = 1'b0;
  logic [31:0] cur_start, cur_len;
  logic [47:0] cur_floor;

  always #1 clk = ~clk;

  trade_ohlc_bar_aggregator_unit DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_ready, .in_action, .in_trade_time, .in_base_volume,
    .in_rel_volume, .in_bar_select, .out_valid, .out_ready,
    .out_status(out_res.status), .out_bar_valid(out_res.bar_valid),
    .out_bar_start(out_res.bar_start), .out_price_high(out_res.price_high),
    .out_price_low(out_res.price_low), .out_price_open(out_res.price_open),
    .out_price_close(out_res.price_close), .out_rel_total(out_res.rel_total),
    .out_base_total(out_res.base_total),
    .out_average_price(out_res.average_price),
    .out_trade_count(out_res.trade_count)
  );

  ohlc_bar_checker u_checker (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_valid, .in_ready,
    .in_action, .in_trade_time, .in_base_volume, .in_rel_volume, .in_bar_select,
    .out_valid, .out_ready, .out_res, .fail_count, .pending
  );

  // Receiver: random stalls, none while calm, a full stall during hold-off
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 9);
  end

  // Watchdog: count cycles with no transaction on either channel, outside reset and hold-off
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_WSTART) cur_start = val[31:0];
    if (idx == CFG_BARSEC)
      cur_len = (val[31:0] < MIN_BAR_SECONDS) ? MIN_BAR_SECONDS : val[31:0];
    if (idx == CFG_MINVOL) cur_floor = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Send one transaction, with an occasional gap before it; valid stays
  // high after acceptance until the next gap, item or drain
  task automatic send(logic [1:0] act, logic [31:0] t, logic [47:0] bv,
                      logic [47:0] rv, logic [9:0] sel);
    while (!calm && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_trade_time <= t;
    in_base_volume <= bv;
    in_rel_volume <= rv;
    in_bar_select <= sel;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Trade aimed at a low bar of the current window, mostly well formed
  task automatic random_trade();
    logic [31:0] t;
    logic [47:0] bv, rv;
    int          k;
    k = $urandom_range(99);
    t = cur_start + $urandom_range(7) * cur_len + $urandom_range(cur_len - 1);
    if (k < 8) t = $urandom();
    bv = cur_floor + 1 + $urandom_range(100000);
    rv = cur_floor + 1 + $urandom_range(100000);
    if (k >= 8 && k < 14) bv = 48'({$urandom(), $urandom()});
    if (k >= 14 && k < 20) rv = 48'({$urandom(), $urandom()});
    if (k >= 20 && k < 24) bv = cur_floor;
    send(ACT_TRADE, t, bv, rv, 10'($urandom()));
  endtask

  task automatic random_item();
    int k;
    k = $urandom_range(99);
    if (k < 65) random_trade();
    else if (k < 88) send(ACT_READ, $urandom(), 48'({$urandom(), $urandom()}),
                          48'({$urandom(), $urandom()}), 10'($urandom_range(9)));
    else if (k < 94) send(ACT_CLEAR, $urandom(), '0, '0, 10'($urandom_range(9)));
    else if (k < 97) send(ACT_READ, '0, '0, '0, 10'($urandom()));
    else send(ACT_SPARE, $urandom(), '0, '0, 10'($urandom()));
  endtask

  initial begin
    cur_start = 0;
    cur_len = 60;
    cur_floor = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every action, each corner case
    write_reg(CFG_WSTART, 48'd1000);
    write_reg(CFG_WEND, 48'hFFFF_FFFF);
    write_reg(CFG_BARSEC, 48'd10);
    write_reg(CFG_MINVOL, 48'd0);
    send(ACT_TRADE, 32'd0, 48'd5, 48'd5, '0);
    send(ACT_TRADE, 32'd999, 48'd5, 48'd5, '0);
    send(ACT_TRADE, 32'd1000, 48'd3, 48'd7, '0);
    send(ACT_TRADE, 32'd1059, 48'h1, 48'hFFFF_FFFF_FFFF, '0);
    send(ACT_TRADE, 32'd1030, 48'hFFFF_FFFF_FFFF, 48'h1, '0);
    send(ACT_TRADE, 32'd1040, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, '0);
    send(ACT_TRADE, 32'd1050, 48'd0, 48'd9, '0);
    send(ACT_TRADE, 32'hFFFF_FFFF, 48'd2, 48'd2, '0);
    send(ACT_TRADE, 32'd1000 + 1023 * 60 + 59, 48'd2, 48'd3, '0);
    send(ACT_READ, '0, '0, '0, 10'd0);
    send(ACT_READ, '0, '0, '0, 10'd1023);
    send(ACT_READ, '0, '0, '0, 10'd500);
    send(ACT_CLEAR, '0, '0, '0, 10'd0);
    send(ACT_READ, '0, '0, '0, 10'd0);
    send(ACT_SPARE, '1, '1, '1, '1);
    drain();
    write_reg(CFG_WSTART, 48'hFFFF_FFFF);
    write_reg(CFG_WEND, 48'd5);
    send(ACT_TRADE, 32'd3, 48'd5, 48'd5, '0);
    send(ACT_TRADE, 32'hFFFF_FFFF, 48'd5, 48'd5, '0);
    send(ACT_READ, '0, '0, '0, 10'd1023);
    drain();
    write_reg(CFG_WSTART, 48'd0);
    write_reg(CFG_WEND, 48'hFFFF_FFFF);
    write_reg(CFG_BARSEC, 48'hFFFF_FFFF);
    write_reg(CFG_MINVOL, 48'hFFFF_FFFF_FFFE);
    send(ACT_TRADE, 32'd77, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, '0);
    send(ACT_TRADE, 32'd78, 48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF, '0);
    send(ACT_READ, '0, '0, '0, 10'd0);
    send(ACT_READ, '0, '0, '0, 10'd1);
    drain();

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_WSTART, (ph == 5) ? 48'd0 : 48'($urandom()));
      write_reg(CFG_WEND, (ph == 3) ? 48'($urandom()) : 48'hFFFF_FFFF);
      write_reg(CFG_BARSEC, (ph == 0) ? 48'd0 : 48'($urandom_range(3600)));
      write_reg(CFG_MINVOL, (ph == 4) ? 48'($urandom_range(50000)) : 48'd0);
      calm = (ph == 2);
      if (ph == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (800) @(posedge clk);
            hold_off = 1'b0;
          end
          repeat (160) random_item();
        join
      end else begin
        repeat (155) random_item();
      end
      calm = 1'b0;
      drain();
    end

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
